@@ hdl/u16u8_pkg.sv @@
package u16u8_pkg;

  // Queue between the front end and the byte serializer.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // Code point constants.
  localparam logic [20:0] Replacement = 21'h00fffd;
  localparam logic [20:0] SuppBase    = 21'h010000;

  // High and low surrogates share the top bits 110110 and 110111.
  localparam logic [5:0] HighTag = 6'b110110;
  localparam logic [5:0] LowTag  = 6'b110111;

  // One queued job: an optional replacement character first, then an optional code point.
  typedef struct packed {
    logic        rep_first;
    logic        has_cp;
    logic [20:0] cp;
  } job_t;

endpackage

@@ hdl/u16u8_front.sv @@
module u16u8_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        code_unit_i,
  input  logic               end_of_text_i,
  input  logic               full_i,
  output logic               push_o,
  output u16u8_pkg::job_t    job_o
);

  logic       pend_q, pend_d;
  logic [9:0] held_q, held_d;
  logic       is_high, is_low, accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign is_high    = (code_unit_i[15:10] == u16u8_pkg::HighTag);
  assign is_low     = (code_unit_i[15:10] == u16u8_pkg::LowTag);

  // Classify the unit against the held surrogate and build the job.
  always_comb begin
    pend_d          = pend_q;
    held_d          = held_q;
    job_o.rep_first = 1'b0;
    job_o.has_cp    = 1'b1;
    job_o.cp        = {5'd0, code_unit_i};
    if (pend_q && is_low) begin
      job_o.cp = u16u8_pkg::SuppBase + {1'b0, held_q, code_unit_i[9:0]};
      pend_d   = 1'b0;
      held_d   = '0;
    end else begin
      job_o.rep_first = pend_q;
      pend_d          = 1'b0;
      held_d          = '0;
      if (is_high) begin
        if (end_of_text_i) begin
          job_o.cp = u16u8_pkg::Replacement;
        end else begin
          job_o.has_cp = 1'b0;
          pend_d       = 1'b1;
          held_d       = code_unit_i[9:0];
        end
      end else if (is_low) begin
        job_o.cp = u16u8_pkg::Replacement;
      end
    end
  end

  // A held surrogate with nothing else to send produces no job.
  assign push_o = accept && (job_o.rep_first || job_o.has_cp);

  // Surrogate hold state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      held_q <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      held_q <= held_d;
    end
  end

`ifndef SYNTHESIS
  // The held bits are cleared whenever no surrogate is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !pend_q |-> (held_q == 10'd0))
    else $error("held surrogate bits not cleared");
`endif

endmodule

@@ hdl/u16u8_fifo.sv @@
module u16u8_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  u16u8_pkg::job_t    job_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output u16u8_pkg::job_t    job_o
);

  u16u8_pkg::job_t                  mem_q [u16u8_pkg::FifoDepth];
  logic [u16u8_pkg::FifoAw-1:0]     wr_q, rd_q;
  logic [u16u8_pkg::FifoAw:0]       cnt_q;

  assign full_o  = (cnt_q == (u16u8_pkg::FifoAw+1)'(u16u8_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("queue underflow");
`endif

endmodule

@@ hdl/u16u8_back.sv @@
module u16u8_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  u16u8_pkg::job_t    job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               last_of_run_o
);

  // Number of UTF-8 bytes for a code point.
  function automatic logic [2:0] enc_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp <= 21'h00007f) begin
      len = 3'd1;
    end else if (cp <= 21'h0007ff) begin
      len = 3'd2;
    end else if (cp <= 21'h00ffff) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Byte k of the UTF-8 encoding of a code point of the given length.
  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [2:0] len,
                                          input logic [1:0] k);
    logic [7:0] b;
    b = {2'b10, cp[5:0]};
    case (len)
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        case (k)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (k)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

  logic [2:0] idx_q, idx_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic [2:0] rep_len, cp_len, total, cp_k;
  logic       in_rep, is_last, load;
  logic [7:0] cur_byte;

  // Select the byte at the current position of the head job.
  always_comb begin
    rep_len  = job_i.rep_first ? 3'd3 : 3'd0;
    cp_len   = job_i.has_cp ? enc_len(job_i.cp) : 3'd0;
    total    = rep_len + cp_len;
    in_rep   = job_i.rep_first && (idx_q < 3'd3);
    cp_k     = idx_q - rep_len;
    cur_byte = in_rep ? enc_byte(u16u8_pkg::Replacement, 3'd3, idx_q[1:0])
                      : enc_byte(job_i.cp, cp_len, cp_k[1:0]);
    is_last  = (idx_q == total - 3'd1);
  end

  // The output register takes a byte whenever it is empty or being drained.
  assign load  = !empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && is_last;

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= !empty_i;
        out_byte_q  <= cur_byte;
        out_last_q  <= is_last;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

`ifndef SYNTHESIS
  // The byte position never runs past the end of the head job.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !empty_i |-> (idx_q < total))
    else $error("byte position beyond job length");
`endif

endmodule

@@ hdl/utf16_to_utf8_transcoder_unit.sv @@
// The first byte of an item passes through the job queue and then the output register.
// Output: one byte per cycle while out_stall_i is low; an item produces 0 to 6 bytes
// (typically 1 to 3), sent one at a time through the byte-wide output register.
// A four-entry job queue lets the input side run ahead of the output side.
// Reset (rst_ni low, asynchronous) clears the held surrogate, the queue and the output.
module utf16_to_utf8_transcoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] code_unit_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o
);

  u16u8_pkg::job_t push_job, head_job;
  logic            push, pop, full, empty;

  // Front end: surrogate pairing and job classification.
  u16u8_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .code_unit_i   (code_unit_i),
    .end_of_text_i (end_of_text_i),
    .full_i        (full),
    .push_o        (push),
    .job_o         (push_job)
  );

  // Job queue between the two sides.
  u16u8_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (head_job)
  );

  // Back end: UTF-8 encoding and byte serialization.
  u16u8_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .job_i         (head_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

@@ bench/utf8_stream_checker.sv @@
`timescale 1ns / 100ps

module utf8_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [15:0] code_unit_i,
  input  logic        end_of_text_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_of_run_i,
  output int unsigned bytes_due_o,
  output int unsigned fail_count_o
);

  localparam logic [5:0]  HighPrefix  = 6'b110110;
  localparam logic [5:0]  LowPrefix   = 6'b110111;
  localparam logic [20:0] Replacement = 21'h00fffd;
  localparam logic [20:0] SuppBase    = 21'h010000;

  // One expected UTF-8 byte and its end-of-run flag.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_byte_t;

  utf8_byte_t  utf8_due_q[$];
  logic [7:0]  run_bytes_q[$];
  logic        held_valid = 1'b0;
  logic [9:0]  held_bits  = '0;
  int unsigned fail_count = 0;

  assign fail_count_o = fail_count;

  // Add one byte at the end of the current run.
  task automatic append_byte(input logic [7:0] b);
    run_bytes_q.insert(run_bytes_q.size(), b);
  endtask

  // Append the UTF-8 encoding of one code point to the current run.
  task automatic add_code_point(input logic [20:0] cp);
    if (cp <= 21'h00007f) begin
      append_byte({1'b0, cp[6:0]});
    end else if (cp <= 21'h0007ff) begin
      append_byte({3'b110, cp[10:6]});
      append_byte({2'b10, cp[5:0]});
    end else if (cp <= 21'h00ffff) begin
      append_byte({4'b1110, cp[15:12]});
      append_byte({2'b10, cp[11:6]});
      append_byte({2'b10, cp[5:0]});
    end else begin
      append_byte({5'b11110, cp[20:18]});
      append_byte({2'b10, cp[17:12]});
      append_byte({2'b10, cp[11:6]});
      append_byte({2'b10, cp[5:0]});
    end
  endtask

  // Work out the bytes that one accepted code unit causes and queue them.
  task automatic predict_unit(input logic [15:0] unit, input logic eot);
    logic       is_high;
    logic       is_low;
    utf8_byte_t entry;
    is_high = (unit[15:10] == HighPrefix);
    is_low  = (unit[15:10] == LowPrefix);
    run_bytes_q.delete();
    if (held_valid && is_low) begin
      // A complete surrogate pair ends the run by itself.
      held_valid = 1'b0;
      add_code_point(SuppBase + {1'b0, held_bits, unit[9:0]});
      held_bits  = '0;
    end else begin
      // A held high surrogate without its partner becomes a replacement character.
      if (held_valid) begin
        held_valid = 1'b0;
        held_bits  = '0;
        add_code_point(Replacement);
      end
      if (is_high) begin
        if (eot) begin
          add_code_point(Replacement);
        end else begin
          held_valid = 1'b1;
          held_bits  = unit[9:0];
        end
      end else if (is_low) begin
        add_code_point(Replacement);
      end else begin
        add_code_point({5'd0, unit});
      end
    end
    foreach (run_bytes_q[k]) begin
      entry.data = run_bytes_q[k];
      entry.last = (k == run_bytes_q.size() - 1);
      utf8_due_q.insert(utf8_due_q.size(), entry);
    end
  endtask

  // Compare each output transfer with the oldest expected byte, then predict new input.
  always @(posedge clk_i) begin : monitor
    utf8_byte_t due;
    if (!rst_ni) begin
      held_valid = 1'b0;
      held_bits  = '0;
      utf8_due_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (utf8_due_q.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected byte, expected none, got %h (last %b)",
                   $time, out_byte_i, last_of_run_i);
        end else begin
          due = utf8_due_q.pop_front();
          if (out_byte_i !== due.data) begin
            fail_count++;
            $display("%0t ns: out_byte mismatch, expected %h, got %h",
                     $time, due.data, out_byte_i);
          end
          if (last_of_run_i !== due.last) begin
            fail_count++;
            $display("%0t ns: last_of_run mismatch, expected %b, got %b",
                     $time, due.last, last_of_run_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_unit(code_unit_i, end_of_text_i);
      end
    end
    bytes_due_o <= utf8_due_q.size();
  end

endmodule

@@ bench/tb_utf16_to_utf8_transcoder_unit.sv @@
`timescale 1ns / 100ps

module tb_utf16_to_utf8_transcoder_unit;

  localparam int unsigned RandomUnits = 126;
  localparam int unsigned FloodUnits  = 30;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned SettleDelay = 30;
  localparam int unsigned CycleLimit  = 200000;

  logic        clk_i;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] code_unit;
  logic        end_of_text;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        last_of_run;

  int unsigned bytes_due;
  int unsigned fail_count;
  int unsigned units_sent;
  int unsigned cycle_count;
  bit          flood_mode;

  utf16_to_utf8_transcoder_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .code_unit_i   (code_unit),
    .end_of_text_i (end_of_text),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_byte_o    (out_byte),
    .last_of_run_o (last_of_run)
  );

  utf8_stream_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .code_unit_i   (code_unit),
    .end_of_text_i (end_of_text),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_byte_i    (out_byte),
    .last_of_run_i (last_of_run),
    .bytes_due_o   (bytes_due),
    .fail_count_o  (fail_count)
  );

  // Free-running 100 MHz clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Stop a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[utf16_to_utf8_transcoder_unit] ERROR");
    $finish;
  end

  // Offer one code unit after a random gap and wait for its transfer.
  int unsigned send_stretch = 0;
  bit          send_eager   = 1'b0;

  task automatic send_unit(input logic [15:0] unit, input logic eot);
    int unsigned gap;
    if (send_stretch == 0) begin
      send_stretch = $urandom_range(10, 40);
      send_eager   = ($urandom_range(0, 3) == 0);
    end
    send_stretch--;
    gap = (flood_mode || send_eager) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    code_unit   <= unit;
    end_of_text <= eot;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    units_sent++;
  endtask

  // Stop offering and wait until every expected byte has arrived.
  task automatic pause_for_drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (bytes_due != 0) @(posedge clk_i);
  endtask

  // One random character: mostly well-formed text, some stray surrogates and noise.
  task automatic send_random_char();
    int unsigned pct;
    logic [15:0] unit;
    logic        eot;
    pct = $urandom_range(0, 99);
    eot = ($urandom_range(0, 7) == 0);
    if (pct < 30) begin
      send_unit(16'($urandom_range(16'h0000, 16'h007f)), eot);
    end else if (pct < 45) begin
      send_unit(16'($urandom_range(16'h0080, 16'h07ff)), eot);
    end else if (pct < 65) begin
      unit = 16'($urandom_range(16'h0800, 16'hffff));
      if (unit[15:11] == 5'b11011) begin
        unit = unit ^ 16'h2000;
      end
      send_unit(unit, eot);
    end else if (pct < 88) begin
      send_unit(16'hd800 | 16'($urandom_range(0, 1023)), 1'b0);
      send_unit(16'hdc00 | 16'($urandom_range(0, 1023)), eot);
    end else if (pct < 93) begin
      send_unit(16'($urandom_range(0, 16'hffff)), eot);
    end else if (pct < 97) begin
      send_unit(16'hd800 | 16'($urandom_range(0, 1023)), eot);
    end else begin
      send_unit(16'hdc00 | 16'($urandom_range(0, 1023)), eot);
    end
  endtask

  // Output side: random stalls, no-stall stretches, and one long hold once the flood starts.
  initial begin : receiver
    int unsigned hold_off;
    int unsigned stretch_left;
    bit          eager;
    bit          long_hold_done;
    out_stall     <= 1'b0;
    stretch_left   = 0;
    eager          = 1'b0;
    long_hold_done = 1'b0;
    @(posedge clk_i);
    while (!rst_n) @(posedge clk_i);
    forever begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(10, 40);
        eager        = ($urandom_range(0, 3) == 0);
      end
      stretch_left--;
      hold_off = eager ? 0 : $urandom_range(0, 8);
      if (flood_mode && !long_hold_done) begin
        hold_off      += LongHold;
        long_hold_done = 1'b1;
      end
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  // Input side: reset, directed cases, a flood against a held-off output, random text.
  initial begin : stimulus
    int unsigned start;
    in_valid    <= 1'b0;
    code_unit   <= '0;
    end_of_text <= 1'b0;
    rst_n        = 1'b0;
    units_sent   = 0;
    flood_mode   = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Encoding length boundaries.
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007f, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07ff, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hd7ff, 1'b0);
    send_unit(16'he000, 1'b0);
    send_unit(16'hffff, 1'b1);
    // Surrogate pairs at the ends of the supplementary range.
    send_unit(16'hd800, 1'b0);
    send_unit(16'hdc00, 1'b0);
    send_unit(16'hdbff, 1'b0);
    send_unit(16'hdfff, 1'b1);
    // Held high surrogate followed by an ordinary character.
    send_unit(16'hd83d, 1'b0);
    send_unit(16'h0041, 1'b0);
    // Held high surrogate followed by another high surrogate, which then pairs.
    send_unit(16'hd800, 1'b0);
    send_unit(16'hdbff, 1'b0);
    send_unit(16'hdc01, 1'b0);
    // Held high surrogate, then a high surrogate at end of text: two replacements.
    send_unit(16'hd801, 1'b0);
    send_unit(16'hda00, 1'b1);
    // High surrogate at end of text, then lone low surrogates.
    send_unit(16'hdbff, 1'b1);
    send_unit(16'hdc00, 1'b0);
    send_unit(16'hdfff, 1'b1);
    // Held high surrogate followed by a plain character at end of text.
    send_unit(16'hdabc, 1'b0);
    send_unit(16'hfffd, 1'b1);
    pause_for_drain();

    // Flood the input while the output holds off, so the queue fills up.
    flood_mode = 1'b1;
    start      = units_sent;
    while (units_sent - start < FloodUnits) begin
      send_random_char();
    end
    flood_mode = 1'b0;
    pause_for_drain();

    // Random text, with a full drain now and then.
    start = units_sent;
    while (units_sent - start < RandomUnits) begin
      send_random_char();
      if ($urandom_range(0, 59) == 0) begin
        pause_for_drain();
      end
    end
    pause_for_drain();
    repeat (SettleDelay) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[utf16_to_utf8_transcoder_unit] OK");
    end else begin
      $display("[utf16_to_utf8_transcoder_unit] ERROR");
    end
    $finish;
  end

endmodule
